// ===== rtl/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SQRT_STEPS = 33;
    localparam int QUO_BITS = 33;
    localparam int NUM_W = 35 + FRAC_BITS;

    localparam logic [1:0] ADDR_ZERO_THRESHOLD = 2'd0;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_ANY  = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [31:0] coef_quadratic;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_constant;
    } req_t;

    typedef struct packed {
        logic [1:0]         root_kind;
        logic signed [31:0] first_root;
        logic signed [31:0] second_root;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [32:0] den;
        logic signed [32:0] nbase;
    } sqrt_meta_t;

    typedef struct packed {
        logic [34:0] rem;
        logic [32:0] root;
        logic [65:0] rad;
    } sqrt_state_t;

    typedef struct packed {
        logic [32:0]      rem;
        logic [32:0]      quo;
        logic [NUM_W-1:0] nm;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        kind_t       kind;
        logic [32:0] dm;
    } div_tag_t;

endpackage

// ===== rtl/qrs_sqrt_cell.sv =====
// One digit step of the pipelined integer square root.
module qrs_sqrt_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  qrs_pkg::sqrt_state_t    in_st,
    input  qrs_pkg::sqrt_meta_t     in_meta,
    output logic                    out_valid,
    output qrs_pkg::sqrt_state_t    out_st,
    output qrs_pkg::sqrt_meta_t     out_meta
);

    logic                 valid_reg;
    qrs_pkg::sqrt_state_t st_reg, st_next;
    qrs_pkg::sqrt_meta_t  meta_reg;
    logic [36:0]          trial;
    logic [36:0]          test;

    always_comb
    begin
        trial = {in_st.rem, in_st.rad[65:64]};
        test  = {2'b00, in_st.root, 2'b01};
        st_next.rad = {in_st.rad[63:0], 2'b00};
        if (trial >= test)
        begin
            st_next.rem  = 35'(trial - test);
            st_next.root = {in_st.root[31:0], 1'b1};
        end
        else
        begin
            st_next.rem  = trial[34:0];
            st_next.root = {in_st.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        meta_reg <= in_meta;
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_meta  = meta_reg;

endmodule

// ===== rtl/qrs_div_cell.sv =====
// One quotient bit of the two pipelined restoring dividers.
module qrs_div_cell #(
    parameter int BIT = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  qrs_pkg::div_lane_t    in_l1,
    input  qrs_pkg::div_lane_t    in_l2,
    input  qrs_pkg::div_tag_t     in_tag,
    output logic                  out_valid,
    output qrs_pkg::div_lane_t    out_l1,
    output qrs_pkg::div_lane_t    out_l2,
    output qrs_pkg::div_tag_t     out_tag
);

    logic               valid_reg;
    qrs_pkg::div_lane_t l1_reg, l1_next, l2_reg, l2_next;
    qrs_pkg::div_tag_t  tag_reg;

    function automatic qrs_pkg::div_lane_t step(qrs_pkg::div_lane_t l, logic [32:0] dm);
        logic [33:0]        trial;
        logic               ge;
        qrs_pkg::div_lane_t r;
        trial = {l.rem, l.nm[BIT]};
        ge    = trial >= {1'b0, dm};
        r     = l;
        r.rem = ge ? 33'(trial - {1'b0, dm}) : trial[32:0];
        r.quo = {l.quo[31:0], ge};
        return r;
    endfunction

    always_comb
    begin
        l1_next = step(in_l1, in_tag.dm);
        l2_next = step(in_l2, in_tag.dm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        l1_reg  <= l1_next;
        l2_reg  <= l2_next;
        tag_reg <= in_tag;
    end

    assign out_valid = valid_reg;
    assign out_l1    = l1_reg;
    assign out_l2    = l2_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// Top level of the quadratic root solver: front end, sqrt and divider chains, output.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-----------------------------
//  request   | start, busy, req                       | taken when start && !busy
//  result    | done, rsp                              | one-cycle strobe, no backpressure
//  config    | psel penable pwrite paddr pwdata       | APB write, pready tied high
//            | prdata pready                          |
//
// One request per clock; busy is never raised. Pipeline: input register,
// multiply stage, discriminant stage, 33 square-root cells, numerator
// stage, 33 divider cells and the output register. The square-root and divider
// chains produce one result bit per cell. Reset clears all valid bits
// and sets zero_threshold to 1. The receiver cannot stall.
module quadratic_root_solver_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  qrs_pkg::req_t  req,
    output logic           done,
    output qrs_pkg::rsp_t  rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int SQ = qrs_pkg::SQRT_STEPS;
    localparam int QB = qrs_pkg::QUO_BITS;
    localparam int NW = qrs_pkg::NUM_W;

    // ---- configuration register ----
    logic [15:0] thr_reg;
    logic [15:0] thr_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 16'd1;
        else if (psel && penable && pwrite && paddr == qrs_pkg::ADDR_ZERO_THRESHOLD)
            thr_reg <= pwdata[15:0];
    end

    assign thr_eff = (thr_reg == 16'd0) ? 16'd1 : thr_reg;
    assign prdata  = {16'd0, thr_reg};
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    // ---- stage 0: request register ----
    logic          v0_reg;
    qrs_pkg::req_t r0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            r0_reg <= req;
    end

    // ---- stage 1: magnitudes, products, zero tests ----
    logic [31:0] ma, mb, mc;
    logic        v1_reg;
    logic [63:0] b2_reg, p_reg;
    logic signed [31:0] a1_reg, b1_reg, c1_reg;
    logic        za_reg, zb_reg, zc_reg;

    assign ma = r0_reg.coef_quadratic[31] ? 32'(-r0_reg.coef_quadratic)
                                           : r0_reg.coef_quadratic;
    assign mb = r0_reg.coef_linear[31] ? 32'(-r0_reg.coef_linear) : r0_reg.coef_linear;
    assign mc = r0_reg.coef_constant[31] ? 32'(-r0_reg.coef_constant)
                                          : r0_reg.coef_constant;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        b2_reg <= mb * mb;
        p_reg  <= ma * mc;
        a1_reg <= r0_reg.coef_quadratic;
        b1_reg <= r0_reg.coef_linear;
        c1_reg <= r0_reg.coef_constant;
        za_reg <= ma < {16'd0, thr_eff};
        zb_reg <= mb < {16'd0, thr_eff};
        zc_reg <= mc < {16'd0, thr_eff};
    end

    // ---- stage 2: discriminant and classification ----
    logic [65:0]          four, b2e, dm;
    logic                 dneg, dsmall;
    qrs_pkg::sqrt_state_t sq_in;
    qrs_pkg::sqrt_meta_t  meta_in;

    always_comb
    begin
        four = {p_reg, 2'b00};
        b2e  = {2'b00, b2_reg};
        dneg = 1'b0;
        if (p_reg == 64'd0 || (a1_reg[31] != c1_reg[31]))
            dm = b2e + four;
        else if (four <= b2e)
            dm = b2e - four;
        else
        begin
            dneg = 1'b1;
            dm   = four - b2e;
        end
        dsmall = dm < {34'd0, thr_eff, 16'd0};

        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.rad  = '0;
        meta_in.den   = {a1_reg, 1'b0};
        meta_in.nbase = 33'(-{b1_reg[31], b1_reg});
        priority if (!za_reg)
        begin
            if (dsmall)
                meta_in.kind = qrs_pkg::KIND_ONE;
            else if (dneg)
                meta_in.kind = qrs_pkg::KIND_NONE;
            else
            begin
                meta_in.kind = qrs_pkg::KIND_TWO;
                sq_in.rad    = dm;
            end
        end
        else if (!zb_reg)
        begin
            meta_in.kind  = qrs_pkg::KIND_ONE;
            meta_in.den   = {b1_reg[31], b1_reg};
            meta_in.nbase = 33'(-{c1_reg[31], c1_reg});
        end
        else if (!zc_reg)
            meta_in.kind = qrs_pkg::KIND_NONE;
        else
            meta_in.kind = qrs_pkg::KIND_ANY;
    end

    logic                 v2_reg;
    qrs_pkg::sqrt_state_t sq0_reg;
    qrs_pkg::sqrt_meta_t  m0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        sq0_reg <= sq_in;
        m0_reg  <= meta_in;
    end

    // ---- square-root chain ----
    logic                 sv [SQ+1];
    qrs_pkg::sqrt_state_t ss [SQ+1];
    qrs_pkg::sqrt_meta_t  sm [SQ+1];

    assign sv[0] = v2_reg;
    assign ss[0] = sq0_reg;
    assign sm[0] = m0_reg;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(sv[i]), .in_st(ss[i]), .in_meta(sm[i]),
            .out_valid(sv[i+1]), .out_st(ss[i+1]), .out_meta(sm[i+1])
        );
    end

    // ---- stage 3: numerators and overflow precheck ----
    logic signed [34:0] n1, n2;
    logic [34:0]        mn1, mn2;
    logic [32:0]        dmag;
    logic signed [32:0] den_s;
    qrs_pkg::div_lane_t l1_in, l2_in;
    qrs_pkg::div_tag_t  tag_in;

    always_comb
    begin
        den_s = sm[SQ].den;
        n1    = {{2{sm[SQ].nbase[32]}}, sm[SQ].nbase} - {2'b00, ss[SQ].root};
        n2    = {{2{sm[SQ].nbase[32]}}, sm[SQ].nbase} + {2'b00, ss[SQ].root};
        mn1   = n1[34] ? 35'(-n1) : n1;
        mn2   = n2[34] ? 35'(-n2) : n2;
        dmag  = den_s[32] ? 33'(-den_s) : den_s;

        l1_in.nm  = {mn1, {qrs_pkg::FRAC_BITS{1'b0}}};
        l1_in.neg = n1[34] ^ den_s[32];
        l1_in.ovf = {{(66-NW){1'b0}}, l1_in.nm} >= {dmag, 33'd0};
        l1_in.rem = 33'(l1_in.nm[NW-1:QB]);
        l1_in.quo = '0;
        l2_in.nm  = {mn2, {qrs_pkg::FRAC_BITS{1'b0}}};
        l2_in.neg = n2[34] ^ den_s[32];
        l2_in.ovf = {{(66-NW){1'b0}}, l2_in.nm} >= {dmag, 33'd0};
        l2_in.rem = 33'(l2_in.nm[NW-1:QB]);
        l2_in.quo = '0;
        tag_in.kind = sm[SQ].kind;
        tag_in.dm   = dmag;
    end

    logic               v3_reg;
    qrs_pkg::div_lane_t d1_reg, d2_reg;
    qrs_pkg::div_tag_t  t3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= sv[SQ];
    end

    always_ff @(posedge clk)
    begin
        d1_reg <= l1_in;
        d2_reg <= l2_in;
        t3_reg <= tag_in;
    end

    // ---- divider chain, quotient MSB first ----
    logic               dv [QB+1];
    qrs_pkg::div_lane_t dl1 [QB+1];
    qrs_pkg::div_lane_t dl2 [QB+1];
    qrs_pkg::div_tag_t  dt [QB+1];

    assign dv[0]  = v3_reg;
    assign dl1[0] = d1_reg;
    assign dl2[0] = d2_reg;
    assign dt[0]  = t3_reg;

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        qrs_div_cell #(.BIT(QB - 1 - j)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(dv[j]), .in_l1(dl1[j]), .in_l2(dl2[j]), .in_tag(dt[j]),
            .out_valid(dv[j+1]), .out_l1(dl1[j+1]), .out_l2(dl2[j+1]), .out_tag(dt[j+1])
        );
    end

    // ---- final: clamp, tiny-negative fix, masking ----
    function automatic logic [32:0] finish(qrs_pkg::div_lane_t l, logic [15:0] thr);
        logic [31:0] r;
        logic        s;
        s = 1'b0;
        if (l.neg)
        begin
            if (l.ovf || l.quo > 33'h0_8000_0000)
            begin
                r = 32'h8000_0000;
                s = 1'b1;
            end
            else if (l.quo < {17'd0, thr})
                r = l.quo[31:0];
            else
                r = 32'(-l.quo[31:0]);
        end
        else
        begin
            if (l.ovf || l.quo > 33'h0_7FFF_FFFF)
            begin
                r = 32'h7FFF_FFFF;
                s = 1'b1;
            end
            else
                r = l.quo[31:0];
        end
        return {s, r};
    endfunction

    logic [32:0]   f1, f2;
    qrs_pkg::rsp_t rsp_next, rsp_reg;
    logic          done_reg;

    always_comb
    begin
        f1 = finish(dl1[QB], thr_eff);
        f2 = finish(dl2[QB], thr_eff);
        rsp_next.root_kind = dt[QB].kind;
        unique case (dt[QB].kind)
            qrs_pkg::KIND_ONE:
            begin
                rsp_next.first_root  = f1[31:0];
                rsp_next.second_root = '0;
                rsp_next.saturated   = f1[32];
            end
            qrs_pkg::KIND_TWO:
            begin
                rsp_next.first_root  = f1[31:0];
                rsp_next.second_root = f2[31:0];
                rsp_next.saturated   = f1[32] | f2[32];
            end
            default:
            begin
                rsp_next.first_root  = '0;
                rsp_next.second_root = '0;
                rsp_next.saturated   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[QB];
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // ---- checks ----
    a_empty_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.root_kind == qrs_pkg::KIND_NONE || rsp.root_kind == qrs_pkg::KIND_ANY)
        |-> rsp.first_root == 0 && rsp.second_root == 0 && !rsp.saturated)
        else $error("roots present for empty kind");

    a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.root_kind == qrs_pkg::KIND_ONE |-> rsp.second_root == 0)
        else $error("second root set for single root");

    a_chain_out: assert property (@(posedge clk) disable iff (!rst_n)
        dv[QB] |=> done)
        else $error("divider output lost");

endmodule
